/* hw/rtl/sdcd_pkg.sv */
// ----------------------------------------------------------------------------
// Serial drive command decoder package
// Shared types, character codes, status codes and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdcd_pkg;

  // Field parse phase, one-hot.
  typedef enum logic [4:0] {
    PH_BETWEEN = 5'b00001,
    PH_SPACE   = 5'b00010,
    PH_SIGN    = 5'b00100,
    PH_DIGITS  = 5'b01000,
    PH_BAD     = 5'b10000
  } phase_t;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Result status codes.
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEADBAND = 2'd0;
  localparam logic [1:0] CFG_DUTY     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

  // Register reset values.
  localparam logic [6:0]  DEADBAND_RST = 7'd50;
  localparam logic [7:0]  DUTY_RST     = 8'd255;
  localparam logic [15:0] TIMEOUT_RST  = 16'd500;

  // Field limits.
  localparam logic [8:0]  SIGNED_MAX = 9'd100;
  localparam logic [8:0]  FLAGS_MAX  = 9'd255;
  localparam logic [8:0]  MAG_SAT    = 9'd256;
  localparam logic [12:0] MAG_SAT_W  = 13'd256;
  localparam logic [12:0] RADIX      = 13'd10;
  localparam logic [2:0]  FIELD_SAT  = 3'd4;
  localparam logic [2:0]  FIELD_THR  = 3'd1;
  localparam logic [2:0]  FIELD_TRN  = 3'd2;
  localparam logic [2:0]  FIELD_FLG  = 3'd3;

  // Outcome of closing one field.
  typedef struct packed {
    logic       bad;
    logic       wr_thr;
    logic       wr_trn;
    logic [7:0] value;
  } fin_t;

  // Line events from the parser to the drive control.
  typedef struct packed {
    logic       eol;
    logic       ok;
    logic       overflow;
    logic [7:0] flags;
    logic [7:0] throttle;
    logic [7:0] turn;
  } line_evt_t;

  // One result item.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       drive_update;
    logic [7:0] left_forward_duty;
    logic [7:0] left_reverse_duty;
    logic [7:0] right_reverse_duty;
    logic [7:0] right_forward_duty;
    logic       start_sequence;
    logic [7:0] flags_value;
  } result_t;

endpackage

/* hw/rtl/sdcd_line_parser.sv */
// ----------------------------------------------------------------------------
// Line parser
// Gathers bytes into lines and parses the throttle, turn and flags fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdcd_line_parser #(
  parameter int LINE_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                op,
  input  logic [7:0]          rx_byte,
  output sdcd_pkg::line_evt_t evt
);
  import sdcd_pkg::*;

  localparam int LEN_W = $clog2(LINE_BYTES);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BYTES - 1);

  logic [LEN_W-1:0] line_length, line_length_next;
  logic [2:0]       field_count, field_count_next;
  phase_t           field_phase, field_phase_next;
  logic             minus_seen, minus_seen_next;
  logic [8:0]       field_magnitude, field_magnitude_next;
  logic             line_bad, line_bad_next;
  logic             text_ended, text_ended_next;
  logic [7:0]       held_throttle, held_throttle_next;
  logic [7:0]       held_turn, held_turn_next;

  logic        is_digit;
  logic        is_space;
  logic [3:0]  digit_val;
  logic [12:0] accum;
  fin_t        fin;
  phase_t      eff_phase;

  function automatic fin_t finish_field(phase_t ph, logic [2:0] cnt, logic [8:0] mg,
                                        logic mn);
    fin_t r;
    r = '0;
    if (ph != PH_BETWEEN) begin
      if (ph != PH_DIGITS) begin
        r.bad = 1'b1;
      end else if (cnt == FIELD_THR || cnt == FIELD_TRN) begin
        if (mg > SIGNED_MAX) begin
          r.bad = 1'b1;
        end else begin
          r.value  = mn ? 8'(8'd0 - mg[7:0]) : mg[7:0];
          r.wr_thr = (cnt == FIELD_THR);
          r.wr_trn = (cnt == FIELD_TRN);
        end
      end else if (cnt == FIELD_FLG) begin
        if (mg > FLAGS_MAX || (mn && mg != '0)) begin
          r.bad = 1'b1;
        end
      end
    end
    return r;
  endfunction

  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_space  = ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR)) || (rx_byte == CH_SPACE);
  assign digit_val = rx_byte[3:0];
  assign accum     = {4'd0, field_magnitude} * RADIX + 13'(digit_val);
  assign fin       = finish_field(field_phase, field_count, field_magnitude, minus_seen);
  // A byte that opens a field is handled as in the leading-space phase.
  assign eff_phase = (field_phase == PH_BETWEEN) ? PH_SPACE : field_phase;

  always_comb begin
    line_length_next     = line_length;
    field_count_next     = field_count;
    field_phase_next     = field_phase;
    minus_seen_next      = minus_seen;
    field_magnitude_next = field_magnitude;
    line_bad_next        = line_bad;
    text_ended_next      = text_ended;
    held_throttle_next   = held_throttle;
    held_turn_next       = held_turn;
    evt                  = '0;
    evt.throttle         = held_throttle;
    evt.turn             = held_turn;
    evt.flags            = field_magnitude[7:0];

    if (fire && !op && rx_byte != CH_CR) begin
      if (rx_byte == CH_LF) begin
        if (line_length != '0) begin
          evt.eol = 1'b1;
          evt.ok  = !(line_bad || fin.bad) && (field_count == FIELD_FLG);
          if (fin.wr_thr) held_throttle_next = fin.value;
          if (fin.wr_trn) held_turn_next = fin.value;
          line_length_next     = '0;
          field_count_next     = '0;
          field_phase_next     = PH_BETWEEN;
          minus_seen_next      = 1'b0;
          field_magnitude_next = '0;
          line_bad_next        = 1'b0;
          text_ended_next      = 1'b0;
        end
      end else if (line_length < LEN_LIMIT) begin
        line_length_next = line_length + 1'b1;
        if (!text_ended) begin
          if (rx_byte == CH_NUL || rx_byte == CH_COMMA) begin
            if (fin.bad) line_bad_next = 1'b1;
            if (fin.wr_thr) held_throttle_next = fin.value;
            if (fin.wr_trn) held_turn_next = fin.value;
            field_phase_next = PH_BETWEEN;
            if (rx_byte == CH_NUL) text_ended_next = 1'b1;
          end else begin
            if (field_phase == PH_BETWEEN) begin
              if (field_count < FIELD_SAT) field_count_next = field_count + 1'b1;
              field_phase_next     = PH_SPACE;
              minus_seen_next      = 1'b0;
              field_magnitude_next = '0;
            end
            unique case (eff_phase)
              PH_SPACE: begin
                if (is_space) begin
                  field_phase_next = PH_SPACE;
                end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
                  minus_seen_next  = (rx_byte == CH_MINUS);
                  field_phase_next = PH_SIGN;
                end else if (is_digit) begin
                  field_magnitude_next = {5'd0, digit_val};
                  field_phase_next     = PH_DIGITS;
                end else begin
                  field_phase_next = PH_BAD;
                end
              end
              PH_SIGN: begin
                if (is_digit) begin
                  field_magnitude_next = {5'd0, digit_val};
                  field_phase_next     = PH_DIGITS;
                end else begin
                  field_phase_next = PH_BAD;
                end
              end
              PH_DIGITS: begin
                if (is_digit) begin
                  field_magnitude_next = (accum > MAG_SAT_W) ? MAG_SAT : accum[8:0];
                end else begin
                  field_phase_next = PH_BAD;
                end
              end
              default: begin
                field_phase_next = PH_BAD;
              end
            endcase
          end
        end
      end else begin
        // The line has run out of room: drop it and report.
        evt.overflow         = 1'b1;
        line_length_next     = '0;
        field_count_next     = '0;
        field_phase_next     = PH_BETWEEN;
        minus_seen_next      = 1'b0;
        field_magnitude_next = '0;
        line_bad_next        = 1'b0;
        text_ended_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      field_count     <= '0;
      field_phase     <= PH_BETWEEN;
      minus_seen      <= 1'b0;
      field_magnitude <= '0;
      line_bad        <= 1'b0;
      text_ended      <= 1'b0;
      held_throttle   <= '0;
      held_turn       <= '0;
    end else begin
      line_length     <= line_length_next;
      field_count     <= field_count_next;
      field_phase     <= field_phase_next;
      minus_seen      <= minus_seen_next;
      field_magnitude <= field_magnitude_next;
      line_bad        <= line_bad_next;
      text_ended      <= text_ended_next;
      held_throttle   <= held_throttle_next;
      held_turn       <= held_turn_next;
    end
  end

  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    fire && (evt.eol || evt.overflow) |=> line_length == '0 && field_phase == PH_BETWEEN)
    else $error("line state not cleared after end of line");

endmodule

/* hw/rtl/sdcd_drive_ctrl.sv */
// ----------------------------------------------------------------------------
// Drive control
// Holds the configuration registers, the button edge and the timeout timer,
// and turns line events and ticks into result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdcd_drive_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                op,
  input  sdcd_pkg::line_evt_t evt,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output sdcd_pkg::result_t   res
);
  import sdcd_pkg::*;

  logic [6:0]  deadband_level;
  logic [7:0]  drive_duty;
  logic [15:0] timeout_ticks;

  logic        button_was_pressed, button_was_pressed_next;
  logic        timer_armed, timer_armed_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;

  logic [7:0] thr_mag;
  logic [7:0] trn_mag;
  logic       thr_pos;
  logic       trn_pos;
  logic       pressed;

  assign thr_mag = evt.throttle[7] ? 8'(8'd0 - evt.throttle) : evt.throttle;
  assign trn_mag = evt.turn[7] ? 8'(8'd0 - evt.turn) : evt.turn;
  assign thr_pos = !evt.throttle[7] && (evt.throttle != '0);
  assign trn_pos = !evt.turn[7] && (evt.turn != '0);
  assign pressed = evt.flags[0];

  always_comb begin
    res                     = '0;
    button_was_pressed_next = button_was_pressed;
    timer_armed_next        = timer_armed;
    elapsed_ticks_next      = elapsed_ticks;

    if (fire && op) begin
      if (timer_armed) begin
        if (elapsed_ticks >= timeout_ticks) begin
          timer_armed_next   = 1'b0;
          elapsed_ticks_next = '0;
          res.valid          = 1'b1;
          res.status         = ST_TIMEOUT;
          res.drive_update   = 1'b1;
        end else begin
          elapsed_ticks_next = elapsed_ticks + 1'b1;
        end
      end
    end else if (fire && evt.overflow) begin
      res.valid  = 1'b1;
      res.status = ST_TOO_LONG;
    end else if (fire && evt.eol) begin
      res.valid = 1'b1;
      if (!evt.ok) begin
        res.status = ST_INVALID;
      end else begin
        res.status              = ST_ACCEPTED;
        res.flags_value         = evt.flags;
        timer_armed_next        = 1'b1;
        elapsed_ticks_next      = '0;
        button_was_pressed_next = pressed;
        if (pressed && !button_was_pressed) begin
          res.drive_update   = 1'b1;
          res.start_sequence = 1'b1;
        end else if (!pressed) begin
          res.drive_update = 1'b1;
          if (thr_mag < {1'b0, deadband_level} && trn_mag < {1'b0, deadband_level}) begin
            // Inside the deadband: stop.
          end else if (thr_mag >= trn_mag) begin
            if (thr_pos) begin
              res.left_forward_duty  = drive_duty;
              res.right_forward_duty = drive_duty;
            end else begin
              res.left_reverse_duty  = drive_duty;
              res.right_reverse_duty = drive_duty;
            end
          end else if (trn_pos) begin
            res.left_forward_duty  = drive_duty;
            res.right_reverse_duty = drive_duty;
          end else begin
            res.left_reverse_duty  = drive_duty;
            res.right_forward_duty = drive_duty;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_level     <= DEADBAND_RST;
      drive_duty         <= DUTY_RST;
      timeout_ticks      <= TIMEOUT_RST;
      button_was_pressed <= 1'b0;
      timer_armed        <= 1'b0;
      elapsed_ticks      <= '0;
    end else begin
      button_was_pressed <= button_was_pressed_next;
      timer_armed        <= timer_armed_next;
      elapsed_ticks      <= elapsed_ticks_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DEADBAND: deadband_level <= cfg_data[6:0];
          CFG_DUTY:     drive_duty <= cfg_data[7:0];
          CFG_TIMEOUT:  timeout_ticks <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  a_timer_idle: assert property (@(posedge clk) disable iff (rst)
    !timer_armed |-> elapsed_ticks == '0)
    else $error("elapsed ticks nonzero while timer disarmed");

  a_timeout_stop: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == ST_TIMEOUT |-> res.drive_update &&
      res.left_forward_duty == '0 && res.left_reverse_duty == '0 &&
      res.right_reverse_duty == '0 && res.right_forward_duty == '0)
    else $error("timeout stop does not zero the bridges");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    res.start_sequence |-> res.valid && res.status == ST_ACCEPTED &&
      res.flags_value[0] && res.drive_update && !button_was_pressed)
    else $error("sequence request without a fresh button press");

endmodule

/* hw/rtl/serial_drive_command_decoder.sv */
// ----------------------------------------------------------------------------
// Serial drive command decoder
// Path: an accepted byte or tick is held in the input register, and its result
// is then held in the result register.
// Throughput: one input item per cycle while results are taken; a result that
// waits stalls every input once the input register holds an item.
// Reset: synchronous, active high; clears line state and timer, loads register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_drive_command_decoder #(
  parameter int LINE_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] operation
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] drive_update, [8:1] left_forward_duty, [16:9] left_reverse_duty,
  // [24:17] right_reverse_duty, [32:25] right_forward_duty,
  // [33] start_sequence, [41:34] flags_value, [47:42] zero
  output logic [47:0] m_tdata,
  output logic [1:0]  m_tuser,   // [1:0] status
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sdcd_pkg::*;

  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;
  logic       out_free;
  logic       fire;

  line_evt_t evt;
  result_t   res;
  result_t   out_res;

  assign out_free  = !m_tvalid || m_tready;
  assign fire      = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (out_free) begin
        m_tvalid <= res.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser[0];
      in_byte <= s_tdata;
    end
    if (out_free && res.valid) begin
      out_res <= res;
    end
  end

  sdcd_line_parser #(
    .LINE_BYTES(LINE_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .op      (in_op),
    .rx_byte (in_byte),
    .evt     (evt)
  );

  sdcd_drive_ctrl u_drive (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .op        (in_op),
    .evt       (evt),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  assign m_tuser = out_res.status;
  assign m_tdata = {6'd0, out_res.flags_value, out_res.start_sequence,
                    out_res.right_forward_duty, out_res.right_reverse_duty,
                    out_res.left_reverse_duty, out_res.left_forward_duty,
                    out_res.drive_update};

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(fire))
    else $error("result appeared without a processed request");

endmodule

/* dv/serial_drive_command_decoder_tb.sv */
// ----------------------------------------------------------------------------
// Serial drive command decoder testbench
// Feeds text lines, noise and millisecond ticks into the decoder under random
// sender gaps and receiver stalls. A scoreboard predicts every status and
// drive report from its own copy of the parser, the button and timeout logic,
// and compares each returned report field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_drive_command_decoder_tb;
  import sdcd_pkg::*;

  localparam int LINE_BYTES     = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;

  typedef struct packed {
    logic [1:0] status;
    logic       update;
    logic [7:0] left_fwd;
    logic [7:0] left_rev;
    logic [7:0] right_rev;
    logic [7:0] right_fwd;
    logic       start_seq;
    logic [7:0] flags;
  } drive_result_t;

  class drive_scoreboard;
    logic [6:0]    deadband;
    logic [7:0]    duty;
    logic [15:0]   timeout_lim;
    int            line_len;
    logic [2:0]    fields_seen;
    phase_t        phase;
    logic          negative;
    logic [8:0]    magnitude;
    logic          line_invalid;
    logic          text_done;
    logic [7:0]    last_throttle;
    logic [7:0]    last_turn;
    logic          button_held;
    logic          timer_on;
    logic [15:0]   ticks_since;
    drive_result_t expected_reports[$];
    int            errors;

    function new();
      deadband      = DEADBAND_RST;
      duty          = DUTY_RST;
      timeout_lim   = TIMEOUT_RST;
      last_throttle = '0;
      last_turn     = '0;
      button_held   = 1'b0;
      timer_on      = 1'b0;
      ticks_since   = '0;
      errors        = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len     = 0;
      fields_seen  = '0;
      phase        = PH_BETWEEN;
      negative     = 1'b0;
      magnitude    = '0;
      line_invalid = 1'b0;
      text_done    = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_DEADBAND: deadband = val[6:0];
        CFG_DUTY:     duty = val[7:0];
        CFG_TIMEOUT:  timeout_lim = val;
        default: ;
      endcase
    endfunction

    // Closes the field in progress and latches throttle or turn when in range.
    function void close_field();
      if (phase == PH_BETWEEN)
        return;
      if (phase != PH_DIGITS) begin
        line_invalid = 1'b1;
      end else if (fields_seen == FIELD_THR || fields_seen == FIELD_TRN) begin
        if (magnitude > 100) begin
          line_invalid = 1'b1;
        end else if (fields_seen == FIELD_THR) begin
          last_throttle = negative ? 8'(-magnitude) : magnitude[7:0];
        end else begin
          last_turn = negative ? 8'(-magnitude) : magnitude[7:0];
        end
      end else if (fields_seen == FIELD_FLG) begin
        if (magnitude > 255 || (negative && magnitude != 0))
          line_invalid = 1'b1;
      end
      phase = PH_BETWEEN;
    endfunction

    function void set_duties(inout drive_result_t r, input int left, input int right);
      r.update    = 1'b1;
      r.left_fwd  = 8'((left >= 0) ? left : 0);
      r.left_rev  = 8'((left < 0) ? -left : 0);
      r.right_rev = 8'((right < 0) ? -right : 0);
      r.right_fwd = 8'((right >= 0) ? right : 0);
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_request(logic op, logic [7:0] c);
      drive_result_t r;
      logic pressed, digit;
      int thr, trn, tm, rm, db, d, sgn, m;
      r = '0;
      if (op) begin
        if (!timer_on)
          return;
        if (ticks_since >= timeout_lim) begin
          timer_on    = 1'b0;
          ticks_since = '0;
          r.status    = ST_TIMEOUT;
          set_duties(r, 0, 0);
          expected_reports.push_back(r);
        end else begin
          ticks_since++;
        end
        return;
      end
      if (c == CH_CR)
        return;
      if (c == CH_LF) begin
        if (line_len == 0)
          return;
        close_field();
        if (line_invalid || fields_seen != FIELD_FLG) begin
          r.status = ST_INVALID;
        end else begin
          r.status    = ST_ACCEPTED;
          r.flags     = magnitude[7:0];
          timer_on    = 1'b1;
          ticks_since = '0;
          pressed     = magnitude[0];
          if (pressed && !button_held) begin
            set_duties(r, 0, 0);
            r.start_seq = 1'b1;
          end else if (!pressed) begin
            thr = $signed(last_throttle);
            trn = $signed(last_turn);
            tm  = (thr < 0) ? -thr : thr;
            rm  = (trn < 0) ? -trn : trn;
            db  = int'(deadband);
            d   = int'(duty);
            if (tm < db && rm < db) begin
              set_duties(r, 0, 0);
            end else if (tm >= rm) begin
              sgn = (thr > 0) ? d : -d;
              set_duties(r, sgn, sgn);
            end else if (trn > 0) begin
              set_duties(r, d, -d);
            end else begin
              set_duties(r, -d, d);
            end
          end
          button_held = pressed;
        end
        clear_line();
        expected_reports.push_back(r);
        return;
      end
      // A byte arriving with the line buffer full throws the line away.
      if (line_len >= LINE_BYTES - 1) begin
        clear_line();
        r.status = ST_TOO_LONG;
        expected_reports.push_back(r);
        return;
      end
      line_len++;
      if (text_done)
        return;
      if (c == CH_NUL) begin
        close_field();
        text_done = 1'b1;
        return;
      end
      if (c == CH_COMMA) begin
        close_field();
        return;
      end
      digit = (c >= CH_ZERO && c <= CH_NINE);
      if (phase == PH_BETWEEN) begin
        if (fields_seen < FIELD_SAT)
          fields_seen++;
        phase     = PH_SPACE;
        negative  = 1'b0;
        magnitude = '0;
      end
      case (phase)
        PH_SPACE: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            negative = (c == CH_MINUS);
            phase    = PH_SIGN;
          end else if (digit) begin
            magnitude = 9'(c - CH_ZERO);
            phase     = PH_DIGITS;
          end else if (!((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)) begin
            phase = PH_BAD;
          end
        end
        PH_SIGN: begin
          if (digit) begin
            magnitude = 9'(c - CH_ZERO);
            phase     = PH_DIGITS;
          end else begin
            phase = PH_BAD;
          end
        end
        PH_DIGITS: begin
          if (digit) begin
            m = int'(magnitude) * 10 + int'(c - CH_ZERO);
            magnitude = (m > 256) ? 9'd256 : 9'(m);
          end else begin
            phase = PH_BAD;
          end
        end
        default: phase = PH_BAD;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_report(logic [1:0] st, logic [47:0] d);
      drive_result_t e;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, actual status %0d data %h",
                 $time, st, d);
        return;
      end
      e = expected_reports.pop_front();
      compare_field("status", 8'(e.status), 8'(st));
      compare_field("drive_update", 8'(e.update), 8'(d[0]));
      compare_field("left_forward_duty", e.left_fwd, d[8:1]);
      compare_field("left_reverse_duty", e.left_rev, d[16:9]);
      compare_field("right_reverse_duty", e.right_rev, d[24:17]);
      compare_field("right_forward_duty", e.right_fwd, d[32:25]);
      compare_field("start_sequence", 8'(e.start_seq), 8'(d[33]));
      compare_field("flags_value", e.flags, d[41:34]);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  drive_scoreboard sb = new();
  int  idle_cycles = 0;
  int  items_sent = 0;
  int  burst_left = 0;
  bit  tick_chatter = 1'b0;

  serial_drive_command_decoder #(.LINE_BYTES(LINE_BYTES)) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_report(m_tuser, m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver back-pressure: stretches of always-ready, light and heavy random
  // stalls, and a fixed on/off rhythm.
  initial begin
    int mode, len, k;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(16, 96);
      for (k = 0; k < len; k++) begin
        @(negedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ((k % 7) < 4);
        endcase
      end
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      if (tick_chatter && $urandom_range(0, 23) == 0)
        send_item(1'b1, 8'($urandom_range(0, 255)));
      send_item(1'b0, s[i]);
    end
  endtask

  task automatic send_line(input string s, input bit crlf = 1'b0);
    send_text(s);
    if (crlf)
      send_item(1'b0, CH_CR);
    send_item(1'b0, CH_LF);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Holds off the sender until every predicted report has come back.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic reconfigure(input logic [15:0] db, input logic [15:0] dt,
                             input logic [15:0] to);
    settle();
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_DUTY, dt);
    write_reg(CFG_TIMEOUT, to);
  endtask

  function automatic string field_text(input int v);
    string s;
    int sp;
    s = "";
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        sp = $urandom_range(0, 3);
        s = {s, $sformatf("%c", sp == 0 ? CH_TAB : sp == 1 ? CH_SPACE :
                               sp == 2 ? 8'h0B : 8'h0C)};
      end
    end
    if (v < 0 || (v == 0 && $urandom_range(0, 7) == 0))
      s = {s, "-"};
    else if ($urandom_range(0, 3) == 0)
      s = {s, "+"};
    if ($urandom_range(0, 4) == 0)
      s = {s, "0"};
    return {s, $sformatf("%0d", (v < 0) ? -v : v)};
  endfunction

  function automatic int pick_axis();
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 1) ? 100 : -100;
      1: v = (int'(sb.deadband) + int'($urandom_range(0, 2)) - 1) *
             ($urandom_range(0, 1) ? 1 : -1);
      2: v = int'($urandom_range(0, 260)) - 130;
      default: v = int'($urandom_range(0, 200)) - 100;
    endcase
    return v;
  endfunction

  function automatic string compose_command();
    string s, sep, flg;
    sep = ($urandom_range(0, 9) == 0) ? ",," : ",";
    case ($urandom_range(0, 11))
      0: flg = $urandom_range(0, 1) ? "-0" : $sformatf("-%0d", $urandom_range(1, 255));
      1: flg = field_text($urandom_range(256, 999));
      default: flg = field_text($urandom_range(0, 255));
    endcase
    s = {field_text(pick_axis()), sep, field_text(pick_axis()), ",", flg};
    if ($urandom_range(0, 11) == 0)
      s = {",", s};
    if ($urandom_range(0, 11) == 0)
      s = {s, ","};
    return s;
  endfunction

  // Mostly well-formed commands with random content; the rest are corrupted
  // commands, wrong field counts, raw noise and overlong lines.
  task automatic random_phase(input int budget, input int span);
    int start, kind, k;
    logic [7:0] c;
    string s;
    start = items_sent;
    while (items_sent - start < budget) begin
      kind = $urandom_range(0, 99);
      s = compose_command();
      if (kind < 70) begin
      end else if (kind < 80) begin
        k = $urandom_range(0, s.len() - 1);
        c = 8'($urandom_range(1, 255));
        s[k] = (c == CH_LF) ? CH_COMMA : c;
      end else if (kind < 86) begin
        s = {s, ",", field_text($urandom_range(0, 9))};
      end else if (kind < 90) begin
        s = {field_text($urandom_range(0, 9)), ",", field_text($urandom_range(0, 9))};
      end else if (kind < 95) begin
        s = "";
        repeat ($urandom_range(1, 12)) send_item(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        s = "";
        repeat ($urandom_range(31, 40)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      end
      send_line(s, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0)
        send_ticks($urandom_range(1, span));
    end
  endtask

  initial begin
    string long_line;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed checks with the reset register values.
    send_ticks(3);
    send_line("");
    send_line("", 1'b1);
    send_line("100,-100,0");
    send_line("-100,0,0", 1'b1);
    send_line({" +5,", $sformatf("%c", 8'h0C), "-60,\t 2"});
    send_line({$sformatf("%c", 8'h0B), "10,+070,0"});
    send_line("49,-49,0");
    send_line("0,0,1");
    send_line("0,0,1");
    send_line("0,0,-0");
    send_line("1,2,-1");
    send_line(",1,,2,,,3,");
    send_line("1,2");
    send_line("1,2,3,4,5,6");
    send_line("101,0,0");
    send_line("-101,0,0");
    send_line("99999999,0,0");
    send_line("0,0,256");
    send_line("0,0,255");
    send_line("60,0,254");
    send_text("1,2,4");
    send_item(1'b0, CH_NUL);
    send_line("x9,,");
    send_line("a,1,2");
    send_line("1 ,2,3");
    send_line("+,1,2");
    send_line("  ");
    long_line = "";
    repeat (LINE_BYTES) long_line = {long_line, "7"};
    send_line({long_line, "5,5,0"});

    // Stop after the timeout count, then ignore ticks while disarmed.
    reconfigure(16'(DEADBAND_RST), 16'(DUTY_RST), 16'd2);
    send_line("-80,0,0");
    send_ticks(5);

    tick_chatter = 1'b1;
    reconfigure(16'd0, 16'd0, 16'd0);
    send_line("0,0,0");
    random_phase(120, 3);
    reconfigure(16'd100, 16'd128, 16'd7);
    random_phase(120, 12);
    reconfigure(16'hFFFF, 16'hFF37, 16'd9);
    random_phase(120, 14);
    reconfigure(16'($urandom_range(0, 100)), 16'($urandom_range(0, 255)),
                16'($urandom_range(0, 30)));
    random_phase(120, 40);
    reconfigure(16'(DEADBAND_RST), 16'(DUTY_RST), TIMEOUT_RST);
    random_phase(120, 20);

    // The stop lands on the last of these ticks.
    tick_chatter = 1'b0;
    reconfigure(16'd50, 16'd200, 16'd20);
    send_line("100,0,0");
    send_ticks(21);
    send_line("0,-100,0");

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
